FILE: hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the pressure compensation core
// Field widths, register indexes, pipeline latencies and stage payloads.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int CAL_W  = 16;
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 20;
  localparam int PRES_W = 32;
  localparam int IDX_W  = 3;

  // Internal widths, sized from the ranges of the calibration and raw fields.
  localparam int DT_W   = 25;
  localparam int OFF_W  = 43;
  localparam int SENS_W = 40;

  localparam int FRONT_LATENCY = 6;
  localparam int BACK_LATENCY  = 5;
  localparam int LATENCY       = FRONT_LATENCY + BACK_LATENCY;

  localparam logic [IDX_W-1:0] REG_SENS          = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET        = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_COEF     = 3'd5;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_centi;
  } result_t;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] offset;
    logic [CAL_W-1:0] sens_tempco;
    logic [CAL_W-1:0] offset_tempco;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coef;
  } cal_t;

  // Compensated terms handed from the temperature section to the pressure section.
  typedef struct packed {
    logic        [RAW_W-1:0]  raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } comp_t;

endpackage

FILE: hdl/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg: calibration coefficient registers
// Six 16-bit registers written through a plain write port; reset clears them.
// ----------------------------------------------------------------------------
module bpc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bpc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0] cfg_data,
  output bpc_pkg::cal_t             cal
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENS:          cal.sens          <= cfg_data;
        REG_OFFSET:        cal.offset        <= cfg_data;
        REG_SENS_TEMPCO:   cal.sens_tempco   <= cfg_data;
        REG_OFFSET_TEMPCO: cal.offset_tempco <= cfg_data;
        REG_REF_TEMP:      cal.ref_temp      <= cfg_data;
        REG_TEMP_COEF:     cal.temp_coef     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: temperature, offset and sensitivity pipeline
// Six stages: dT, products, first-order terms, squares, second-order
// corrections, corrected offset and sensitivity.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  bpc_pkg::sample_t sample,
  input  bpc_pkg::cal_t    cal,
  output logic             out_vld,
  output bpc_pkg::comp_t   comp
);
  import bpc_pkg::*;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;

  logic [FRONT_LATENCY-1:0] vld;
  logic [RAW_W-1:0]         d1_pipe [FRONT_LATENCY-1];

  // Stage 1
  logic signed [DT_W-1:0] dt_s1;
  // Stage 2
  logic signed [40:0] pt_s2;
  logic signed [40:0] poff_s2;
  logic signed [40:0] psens_s2;
  logic        [47:0] dsq_s2;
  logic signed [49:0] dsq_full;
  // Stage 3
  logic signed [TEMP_W-1:0] temp_s3;
  logic signed [36:0]       off_s3;
  logic signed [35:0]       sens_s3;
  logic        [16:0]       t2_s3;
  // Stage 4
  logic signed [TEMP_W-1:0] lo;
  logic signed [TEMP_W-1:0] vlo;
  logic signed [39:0]       lo_sq_full;
  logic signed [39:0]       vlo_sq_full;
  logic        [34:0]       lo_sq_s4;
  logic        [34:0]       vlo_sq_s4;
  logic                     low_s4;
  logic                     vlow_s4;
  logic signed [TEMP_W-1:0] temp_s4;
  logic signed [36:0]       off_s4;
  logic signed [35:0]       sens_s4;
  // Stage 5
  logic        [41:0]       off2_s5;
  logic        [38:0]       sens2_s5;
  logic signed [TEMP_W-1:0] temp_s5;
  logic signed [36:0]       off_s5;
  logic signed [35:0]       sens_s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LATENCY-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    d1_pipe[0] <= sample.raw_pressure;
    for (int i = 1; i < FRONT_LATENCY - 1; i++) begin
      d1_pipe[i] <= d1_pipe[i-1];
    end
  end

  // Stage 1: dT = D2 - C5 * 256.
  always_ff @(posedge clk) begin
    dt_s1 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'b0});
  end

  // Stage 2: the four products of dT.
  assign dsq_full = 50'(dt_s1) * 50'(dt_s1);

  always_ff @(posedge clk) begin
    pt_s2    <= 41'(dt_s1) * 41'($signed({1'b0, cal.temp_coef}));
    poff_s2  <= 41'(dt_s1) * 41'($signed({1'b0, cal.offset_tempco}));
    psens_s2 <= 41'(dt_s1) * 41'($signed({1'b0, cal.sens_tempco}));
    dsq_s2   <= dsq_full[47:0];
  end

  // Stage 3: first-order terms. Dropping low bits of a signed product is a
  // floor division.
  always_ff @(posedge clk) begin
    temp_s3 <= TEMP_REF + TEMP_W'($signed(pt_s2[40:23]));
    off_s3  <= $signed({4'b0, cal.offset, 17'b0}) + 37'($signed(poff_s2[40:6]));
    sens_s3 <= $signed({4'b0, cal.sens, 16'b0}) + 36'($signed(psens_s2[40:7]));
    t2_s3   <= dsq_s2[47:31];
  end

  // Stage 4: temp - T2, squares of the distances below 20.00 and -15.00 degrees.
  assign lo          = temp_s3 - TEMP_REF;
  assign vlo         = temp_s3 - TEMP_VLOW;
  assign lo_sq_full  = 40'(lo) * 40'(lo);
  assign vlo_sq_full = 40'(vlo) * 40'(vlo);

  always_ff @(posedge clk) begin
    lo_sq_s4  <= lo_sq_full[34:0];
    vlo_sq_s4 <= vlo_sq_full[34:0];
    low_s4    <= temp_s3 < TEMP_REF;
    vlow_s4   <= temp_s3 < TEMP_VLOW;
    temp_s4   <= (temp_s3 < TEMP_REF) ? temp_s3 - $signed({3'b0, t2_s3}) : temp_s3;
    off_s4    <= off_s3;
    sens_s4   <= sens_s3;
  end

  // Stage 5: second-order corrections, zero at or above 20.00 degrees.
  always_ff @(posedge clk) begin
    if (low_s4) begin
      off2_s5  <= ((42'(lo_sq_s4) * 42'd61) >> 4)
                + (vlow_s4 ? 42'(vlo_sq_s4) * 42'd17 : 42'd0);
      sens2_s5 <= ((39'(lo_sq_s4) * 39'd29) >> 4)
                + (vlow_s4 ? 39'(vlo_sq_s4) * 39'd9 : 39'd0);
    end else begin
      off2_s5  <= '0;
      sens2_s5 <= '0;
    end
    temp_s5 <= temp_s4;
    off_s5  <= off_s4;
    sens_s5 <= sens_s4;
  end

  // Stage 6: corrected offset and sensitivity.
  always_ff @(posedge clk) begin
    comp.raw_pressure <= d1_pipe[FRONT_LATENCY-2];
    comp.temp         <= temp_s5;
    comp.off          <= OFF_W'(off_s5) - $signed({1'b0, off2_s5});
    comp.sens         <= SENS_W'(sens_s5) - $signed({1'b0, sens2_s5});
  end

  assign out_vld = vld[FRONT_LATENCY-1];

endmodule

FILE: hdl/bpc_press.sv
// ----------------------------------------------------------------------------
// bpc_press: pressure pipeline
// Five stages: split product D1 * SENS, product merge, division by 2^21,
// offset subtraction, division by 2^15 into the output register.
// ----------------------------------------------------------------------------
module bpc_press (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  bpc_pkg::comp_t   comp,
  output logic             done,
  output bpc_pkg::result_t result
);
  import bpc_pkg::*;

  logic [BACK_LATENCY-1:0]  vld;
  logic signed [TEMP_W-1:0] temp_pipe [BACK_LATENCY-1];

  // Stage 7
  logic        [43:0]      pp_lo;
  logic signed [44:0]      pp_hi;
  logic signed [OFF_W-1:0] off_s7;
  // Stage 8
  logic signed [63:0]      prod;
  logic signed [OFF_W-1:0] off_s8;
  // Stage 9
  logic signed [63:0]      prod_adj;
  logic signed [42:0]      q1;
  logic signed [OFF_W-1:0] off_s9;
  // Stage 10
  logic signed [43:0]      diff;
  logic signed [43:0]      diff_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_LATENCY-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    temp_pipe[0] <= comp.temp;
    for (int i = 1; i < BACK_LATENCY - 1; i++) begin
      temp_pipe[i] <= temp_pipe[i-1];
    end
  end

  // Stage 7: D1 * SENS as two partial products over the low and high halves.
  always_ff @(posedge clk) begin
    pp_lo  <= 44'(comp.raw_pressure) * 44'(comp.sens[19:0]);
    pp_hi  <= 45'($signed({1'b0, comp.raw_pressure})) * 45'($signed(comp.sens[39:20]));
    off_s7 <= comp.off;
  end

  // Stage 8: merge. The full product stays within 63 bits.
  always_ff @(posedge clk) begin
    prod   <= $signed({pp_hi[43:0], 20'b0}) + $signed({20'b0, pp_lo});
    off_s8 <= off_s7;
  end

  // Stage 9: division by 2^21 toward zero; negative values are biased first.
  assign prod_adj = prod + $signed({43'b0, {21{prod[63]}}});

  always_ff @(posedge clk) begin
    q1     <= $signed(prod_adj[63:21]);
    off_s9 <= off_s8;
  end

  // Stage 10: offset subtraction.
  always_ff @(posedge clk) begin
    diff <= 44'(q1) - 44'(off_s9);
  end

  // Stage 11: division by 2^15 toward zero, kept to 32 bits.
  assign diff_adj = diff + $signed({29'b0, {15{diff[43]}}});

  always_ff @(posedge clk) begin
    result.temp_centi     <= temp_pipe[BACK_LATENCY-2];
    result.pressure_centi <= $signed({{3{diff_adj[43]}}, diff_adj[43:15]});
  end

  assign done = vld[BACK_LATENCY-1];

endmodule

FILE: hdl/baro_pressure_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core: second-order pressure compensation
// An accepted beat passes through the front and pressure pipelines; done is
// high in the cycle in which result holds that beat's compensated output.
// Throughput: one sample pair per cycle while busy is low, set by the fully
// pipelined datapath; with no receiver stall, nothing ever holds the pipeline.
// Reset: synchronous; clears the pipeline valid bits and all coefficients,
// and holds busy high so that no beat is taken while it is asserted.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bpc_pkg::sample_t          sample,
  input  logic                      cfg_we,
  input  logic [bpc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0] cfg_data,
  output logic                      done,
  output bpc_pkg::result_t          result
);
  import bpc_pkg::*;

  cal_t  cal;
  comp_t comp;
  logic  accept;
  logic  front_vld;

  assign busy   = rst;
  assign accept = start && !busy;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  bpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .sample  (sample),
    .cal     (cal),
    .out_vld (front_vld),
    .comp    (comp)
  );

  bpc_press u_press (
    .clk    (clk),
    .rst    (rst),
    .in_vld (front_vld),
    .comp   (comp),
    .done   (done),
    .result (result)
  );

  // Every accepted beat comes out as a done strobe.
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted beat did not produce a result on time");

  // No result appears without a matching accepted beat.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted beat");

  // The handoff between the two sections keeps its timing.
  a_mid_done: assert property (@(posedge clk) disable iff (rst)
    front_vld |-> ##BACK_LATENCY done)
    else $error("pressure section lost or delayed a beat");

endmodule

FILE: bench/baro_pressure_temp_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core_tb: self-checking bench for the core
// Drives raw pressure/temperature pairs under several calibration settings,
// predicts each compensated result in 64-bit integer arithmetic and compares
// it field by field with what the core reports, beat by beat.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_CAL_REGS = 6;

  // Indexes past the last coefficient; writes there must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint TEMP_REF_CENTI  = 2000;
  localparam longint TEMP_COLD_CENTI = -1500;

  class compensation_scoreboard;
    logic [CAL_W-1:0] cal [NUM_CAL_REGS];
    result_t          expected_q [$];
    int               errors;
    int               checked;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      case (idx) inside
        REG_SENS, REG_OFFSET, REG_SENS_TEMPCO,
        REG_OFFSET_TEMPCO, REG_REF_TEMP, REG_TEMP_COEF: begin
          cal[idx] = data;
        end
        default: begin
        end
      endcase
    endfunction

    function result_t compensate(sample_t s);
      longint  d1, d2, c1, c2, c3, c4, c5, c6;
      longint  dt, temp, off, sens, t2, lo, vlo, off2, sens2, p;
      result_t r;
      d1 = longint'(s.raw_pressure);
      d2 = longint'(s.raw_temperature);
      c1 = longint'(cal[REG_SENS]);
      c2 = longint'(cal[REG_OFFSET]);
      c3 = longint'(cal[REG_SENS_TEMPCO]);
      c4 = longint'(cal[REG_OFFSET_TEMPCO]);
      c5 = longint'(cal[REG_REF_TEMP]);
      c6 = longint'(cal[REG_TEMP_COEF]);
      // First-order terms; the shifts floor toward minus infinity.
      dt   = d2 - c5 * 256;
      temp = TEMP_REF_CENTI + ((dt * c6) >>> 23);
      off  = c2 * 131072 + ((c4 * dt) >>> 6);
      sens = c1 * 65536 + ((c3 * dt) >>> 7);
      if (temp < TEMP_REF_CENTI) begin
        t2    = (dt * dt) >>> 31;
        lo    = temp - TEMP_REF_CENTI;
        off2  = 61 * lo * lo / 16;
        sens2 = 29 * lo * lo / 16;
        if (temp < TEMP_COLD_CENTI) begin
          vlo   = temp - TEMP_COLD_CENTI;
          off2  = off2 + 17 * vlo * vlo;
          sens2 = sens2 + 9 * vlo * vlo;
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
      end
      // Both divisions truncate toward zero, as signed SV division does.
      p = (d1 * sens / 2097152 - off) / 32768;
      r.temp_centi     = temp[TEMP_W-1:0];
      r.pressure_centi = p[PRES_W-1:0];
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_q.push_back(compensate(s));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing expected (temp %0d, pressure %0d)",
                         got.temp_centi, got.pressure_centi));
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got.temp_centi !== exp_r.temp_centi)
          report($sformatf("temp_centi got %0d expected %0d",
                           got.temp_centi, exp_r.temp_centi));
        if (got.pressure_centi !== exp_r.pressure_centi)
          report($sformatf("pressure_centi got %0d expected %0d",
                           got.pressure_centi, exp_r.pressure_centi));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  sample_t          sample;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CAL_W-1:0] cfg_data;
  logic             done;
  result_t          result;

  compensation_scoreboard sb = new();
  int                     sender_gap_pct;
  int                     cycles;
  int                     cal_settings;

  baro_pressure_temp_compensation_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Outputs of the core settle after the edge, so the values read here are the
  // ones the edge accepts.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we)
        sb.write_cal(cfg_index, cfg_data);
      if (start && !busy)
        sb.note_sample(sample);
      if (done)
        sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start               <= 1'b1;
    sample.raw_pressure    <= d1;
    sample.raw_temperature <= d2;
    do @(posedge clk); while (busy);
  endtask

  task wait_idle();
    int n;
    n = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task load_cal(input cal_t c);
    write_reg(REG_SENS, c.sens);
    write_reg(REG_OFFSET, c.offset);
    write_reg(REG_SENS_TEMPCO, c.sens_tempco);
    write_reg(REG_OFFSET_TEMPCO, c.offset_tempco);
    write_reg(REG_REF_TEMP, c.ref_temp);
    write_reg(REG_TEMP_COEF, c.temp_coef);
    @(negedge clk);
    cfg_we <= 1'b0;
    cal_settings++;
  endtask

  function automatic cal_t random_cal();
    cal_t c;
    c.sens          = CAL_W'($urandom);
    c.offset        = CAL_W'($urandom);
    c.sens_tempco   = CAL_W'($urandom);
    c.offset_tempco = CAL_W'($urandom);
    c.ref_temp      = CAL_W'($urandom);
    c.temp_coef     = CAL_W'($urandom);
    return c;
  endfunction

  // Half the raw temperatures land near the reference point so that both
  // sides of the 20.00 degree threshold see plenty of traffic.
  task send_random_sample();
    logic [RAW_W-1:0] d2;
    if ($urandom_range(1) == 0)
      d2 = RAW_W'($urandom);
    else
      d2 = RAW_W'({sb.cal[REG_REF_TEMP], 8'h00} + $urandom_range(16383) - 8192);
    send_sample(RAW_W'($urandom), d2);
  endtask

  initial begin
    cal_t c;
    int   gap_pct [4];
    rst            = 1'b1;
    start          = 1'b0;
    sample         = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sender_gap_pct = 0;
    cycles         = 0;
    cal_settings   = 1;
    gap_pct        = '{0, 54, 0, 30};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Coefficients still at their reset value of zero.
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    wait_idle();

    // Typical calibration: nominal point, the 20.00 degree edge, far cold, hot.
    c = '{sens: 16'd46372, offset: 16'd43981, sens_tempco: 16'd29059,
          offset_tempco: 16'd27842, ref_temp: 16'd31553, temp_coef: 16'd28165};
    load_cal(c);
    send_sample(24'd6465444, 24'd8077636);
    send_sample(24'd6465444, {c.ref_temp, 8'h00});
    send_sample(24'd6465444, {c.ref_temp, 8'h00} - 24'd1);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    wait_idle();

    // The temperature shift here is exactly dT/256, which puts the -15.00
    // degree edge at a known raw value; the spare indexes must change nothing.
    c = '{sens: 16'hFFFF, offset: 16'hFFFF, sens_tempco: 16'hFFFF,
          offset_tempco: 16'hFFFF, ref_temp: 16'hFFFF, temp_coef: 16'd32768};
    load_cal(c);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_sample(24'd8000000, 24'd15880960);
    send_sample(24'd8000000, 24'd15880959);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'd8000000, 24'd16776960);
    send_sample(24'd8000000, 24'd16776959);
    wait_idle();

    c = '{sens: 16'hFFFF, offset: 16'hFFFF, sens_tempco: 16'hFFFF,
          offset_tempco: 16'hFFFF, ref_temp: 16'hFFFF, temp_coef: 16'hFFFF};
    load_cal(c);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    wait_idle();

    foreach (gap_pct[ph]) begin
      load_cal(random_cal());
      sender_gap_pct = gap_pct[ph];
      repeat (PHASE_ITEMS) send_random_sample();
      wait_idle();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Compensation run: %0d sample pairs checked over %0d calibration settings,",
             sb.checked, cal_settings);
    $display("with sender gaps of 0, 30 and 54 percent; %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: baro_pressure_temp_compensation_core.f
hdl/bpc_pkg.sv
hdl/bpc_cfg.sv
hdl/bpc_front.sv
hdl/bpc_press.sv
hdl/baro_pressure_temp_compensation_core.sv
bench/baro_pressure_temp_compensation_core_tb.sv
